// ===== hw/rtl/life_generation_row_stencil_assert.svh =====
// Assertion macros for the Life row stencil checker.
// Depends on nothing; macros need clk in scope, and all but the last need rst.
`ifndef LIFE_GENERATION_ROW_STENCIL_ASSERT_SVH
`define LIFE_GENERATION_ROW_STENCIL_ASSERT_SVH

// Same-cycle implication, switched off while reset is held.
`define LGRS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, switched off while reset is held.
`define LGRS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that also holds across reset.
`define LGRS_ASSERT_NEXT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/lgrs_pkg.sv =====
// Shared types and constants for the Life row stencil.
// Used by the output queue, the row unit and the top level; no dependencies.
package lgrs_pkg;

  localparam int ROW_BITS    = 64;
  localparam int WIDTH_BITS  = 7;
  localparam logic [WIDTH_BITS-1:0] WIDTH_RESET = 7'd64;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_IDX   = 2;
  localparam int QUEUE_CNT   = 3;

  // One result beat as it waits in the output queue.
  typedef struct packed {
    logic [ROW_BITS-1:0] cells;
    logic                last;
  } beat_t;

endpackage

// ===== hw/rtl/life_generation_row_stencil.sv =====
// Channel  Dir  Fields (tdata low bit up / tlast)         Beat
// s_*      in   row_cells[63:0] / last_row                one grid row
// m_*      out  next_cells[63:0] / last_out               one new-generation row
// cfg_*    in   grid_width[6:0]                           register write
//
// A row is taken in the cycle it is offered whenever the result queue has two free places.
// With the output always ready the queue never holds more than two beats, so rows stream at
// one per cycle, the last row of a grid included.
// Results are computed in the accepting cycle and written to the queue that drives m_*.
// Reset (rst, synchronous) empties the queue, forgets held rows and sets the width to 64.
// A stalled output only blocks input once the four-entry queue cannot take two more beats.

// Top level of the Life row stencil: one generation of B3/S23, one grid row per beat.
// Depends on lgrs_pkg, lgrs_row and lgrs_out_queue.
module life_generation_row_stencil #(
  parameter int MAX_WIDTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration: grid_width.
  input  logic        cfg_wen,
  input  logic [6:0]  cfg_wdata,
  // Input rows.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // row_cells[63:0]
  input  logic        s_tlast,   // last_row
  // Output rows.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // next_cells[63:0]
  output logic        m_tlast    // last_out
);

  // Width register; lanes only exist up to MAX_WIDTH, so larger values act as MAX_WIDTH.
  logic [lgrs_pkg::WIDTH_BITS-1:0] grid_width;

  // Row window. upper_row stays zero until two rows are held, which stands in
  // for the dead row above the top of the grid.
  logic [MAX_WIDTH-1:0] upper_row;
  logic [MAX_WIDTH-1:0] middle_row;
  logic                 has_middle;

  logic                 accept;
  logic [MAX_WIDTH-1:0] in_mask;
  logic [MAX_WIDTH-1:0] row_in;
  logic [MAX_WIDTH-1:0] first_above;
  logic [MAX_WIDTH-1:0] first_cur;
  logic [MAX_WIDTH-1:0] first_below;
  logic [MAX_WIDTH-1:0] first_row;
  logic [MAX_WIDTH-1:0] second_row;

  logic            push0;
  logic            push1;
  lgrs_pkg::beat_t beat0;
  lgrs_pkg::beat_t beat1;
  logic            room2;
  lgrs_pkg::beat_t head_beat;

  assign accept = s_tvalid && s_tready;

  // Input bits at or beyond the width are dropped before a row is held, so a later,
  // wider setting does not bring them back into play.
  for (genvar c = 0; c < MAX_WIDTH; c++) begin : g_in_mask
    assign in_mask[c] = grid_width > lgrs_pkg::WIDTH_BITS'(c);
  end

  assign row_in = s_tdata[MAX_WIDTH-1:0] & in_mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width <= lgrs_pkg::WIDTH_RESET;
    end else if (cfg_wen) begin
      grid_width <= cfg_wdata;
    end
  end

  // The first row unit produces the row above the incoming one, or the lone row of a
  // one-row grid. The second produces the bottom row when the last row arrives.
  assign first_above = has_middle ? upper_row : '0;
  assign first_cur   = has_middle ? middle_row : row_in;
  assign first_below = has_middle ? row_in : '0;

  lgrs_row #(.WIDTH(MAX_WIDTH)) u_row_first (
    .grid_width (grid_width),
    .above      (first_above),
    .cur        (first_cur),
    .below      (first_below),
    .result     (first_row)
  );

  lgrs_row #(.WIDTH(MAX_WIDTH)) u_row_second (
    .grid_width (grid_width),
    .above      (middle_row),
    .cur        (row_in),
    .below      ('0),
    .result     (second_row)
  );

  // With nothing held and no last flag the row is only stored.
  assign push0       = accept && (has_middle || s_tlast);
  assign push1       = accept && has_middle && s_tlast;
  assign beat0.cells = lgrs_pkg::ROW_BITS'(first_row);
  assign beat0.last  = !has_middle;
  assign beat1.cells = lgrs_pkg::ROW_BITS'(second_row);
  assign beat1.last  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      upper_row  <= '0;
      middle_row <= '0;
      has_middle <= 1'b0;
    end else if (accept) begin
      if (s_tlast) begin
        upper_row  <= '0;
        middle_row <= '0;
        has_middle <= 1'b0;
      end else begin
        upper_row  <= has_middle ? middle_row : '0;
        middle_row <= row_in;
        has_middle <= 1'b1;
      end
    end
  end

  lgrs_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push0     (push0),
    .data0     (beat0),
    .push1     (push1),
    .data1     (beat1),
    .room2     (room2),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (head_beat)
  );

  assign s_tready = room2;
  assign m_tdata  = head_beat.cells;
  assign m_tlast  = head_beat.last;

endmodule

// ===== hw/rtl/lgrs_lane.sv =====
// One cell of the Life stencil: neighbour count and the B3/S23 rule.
// No dependencies.
module lgrs_lane (
  input  logic [2:0] above,
  input  logic [2:0] cur,
  input  logic [2:0] below,
  output logic       alive
);

  logic [3:0] count;

  assign count = 4'(above[0]) + 4'(above[1]) + 4'(above[2])
               + 4'(cur[0]) + 4'(cur[2])
               + 4'(below[0]) + 4'(below[1]) + 4'(below[2]);

  assign alive = (count == 4'd3) || ((count == 4'd2) && cur[1]);

endmodule

// ===== hw/rtl/lgrs_row.sv =====
// One next-generation row: a lane per column and the width masking around them.
// Depends on lgrs_pkg and lgrs_lane.
module lgrs_row #(
  parameter int WIDTH = 64
) (
  input  logic [lgrs_pkg::WIDTH_BITS-1:0] grid_width,
  input  logic [WIDTH-1:0]                above,
  input  logic [WIDTH-1:0]                cur,
  input  logic [WIDTH-1:0]                below,
  output logic [WIDTH-1:0]                result
);

  logic [WIDTH-1:0] mask;
  logic [WIDTH+1:0] above_p;
  logic [WIDTH+1:0] cur_p;
  logic [WIDTH+1:0] below_p;
  logic [WIDTH-1:0] lane_alive;

  // Columns at or beyond the width are dead, and the grid edges pad with dead cells.
  for (genvar c = 0; c < WIDTH; c++) begin : g_mask
    assign mask[c] = grid_width > lgrs_pkg::WIDTH_BITS'(c);
  end

  assign above_p = {1'b0, above & mask, 1'b0};
  assign cur_p   = {1'b0, cur & mask, 1'b0};
  assign below_p = {1'b0, below & mask, 1'b0};

  for (genvar c = 0; c < WIDTH; c++) begin : g_lane
    lgrs_lane u_lane (
      .above (above_p[c+2:c]),
      .cur   (cur_p[c+2:c]),
      .below (below_p[c+2:c]),
      .alive (lane_alive[c])
    );
  end

  // Merge the lanes; columns outside the width are forced to zero.
  assign result = lane_alive & mask;

endmodule

// ===== hw/rtl/lgrs_out_queue.sv =====
// Four-entry result queue that takes up to two beats a cycle and gives one while out_ready.
// Depends on lgrs_pkg.
module lgrs_out_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push0,
  input  lgrs_pkg::beat_t data0,
  input  logic            push1,
  input  lgrs_pkg::beat_t data1,
  output logic            room2,
  output logic            out_valid,
  input  logic            out_ready,
  output lgrs_pkg::beat_t out_data
);

  lgrs_pkg::beat_t entries [lgrs_pkg::QUEUE_DEPTH];

  logic [lgrs_pkg::QUEUE_IDX-1:0] head;
  logic [lgrs_pkg::QUEUE_IDX-1:0] tail;
  logic [lgrs_pkg::QUEUE_CNT-1:0] count;
  logic [1:0]                     push_n;
  logic                           pop;

  assign push_n    = 2'(push0) + 2'(push1);
  assign out_valid = count != '0;
  assign pop       = out_valid && out_ready;
  assign out_data  = entries[head];
  assign room2     = count <= lgrs_pkg::QUEUE_CNT'(lgrs_pkg::QUEUE_DEPTH - 2);

  always_ff @(posedge clk) begin
    if (push0) begin
      entries[tail] <= data0;
    end
    if (push1) begin
      entries[tail + lgrs_pkg::QUEUE_IDX'(1)] <= data1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      tail  <= tail + lgrs_pkg::QUEUE_IDX'(push_n);
      head  <= head + lgrs_pkg::QUEUE_IDX'(pop);
      count <= count + lgrs_pkg::QUEUE_CNT'(push_n) - lgrs_pkg::QUEUE_CNT'(pop);
    end
  end

endmodule

// ===== hw/rtl/lgrs_checker.sv =====
// Port-level checks for the Life row stencil, bound to the top level.
// Depends on life_generation_row_stencil_assert.svh.
`include "life_generation_row_stencil_assert.svh"

module lgrs_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        s_tlast,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata,
  input logic        m_tlast
);

  `LGRS_ASSERT_NEXT_ALWAYS(a_reset_empty, rst, !m_tvalid, "output valid right after reset")
  `LGRS_ASSERT_NEXT(a_last_gives_result, s_tvalid && s_tready && s_tlast, m_tvalid, "no result after last row")
  `LGRS_ASSERT_NOW(a_empty_ready, !m_tvalid, s_tready, "input stalled with an empty queue")
  `LGRS_ASSERT_NEXT(a_stall_holds, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled output beat changed")

endmodule

bind life_generation_row_stencil lgrs_checker u_lgrs_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
